[design/lidar_point_region_filter_macros.svh]
// ----------------------------------------------------------------------------
// lidar_point_region_filter assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset arst_n.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_REGION_FILTER_MACROS_SVH
`define LIDAR_POINT_REGION_FILTER_MACROS_SVH

// Same-cycle implication
`define LPRF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LPRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lprf_pkg.sv]
// ----------------------------------------------------------------------------
// lprf_pkg
// Widths, register indexes and reset values for the lidar point region filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lprf_pkg;

	// Default payload widths
	localparam int COORD_WIDTH_DEF = 18;
	localparam int COUNT_WIDTH_DEF = 20;

	// Configuration register file
	localparam int REG_WIDTH = 17;
	localparam int SQ_WIDTH  = 2 * REG_WIDTH;
	localparam int NUM_REGS  = 7;
	localparam int CFG_IDX_W = $clog2(NUM_REGS);

	typedef logic [REG_WIDTH-1:0] reg_t;
	typedef logic [SQ_WIDTH-1:0]  reg_sq_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FILTER_ENABLE   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MIN_RANGE       = cfg_idx_t'(1);
	localparam cfg_idx_t REG_MAX_RANGE       = cfg_idx_t'(2);
	localparam cfg_idx_t REG_REAR_HALF_WIDTH = cfg_idx_t'(3);
	localparam cfg_idx_t REG_REAR_LENGTH     = cfg_idx_t'(4);
	localparam cfg_idx_t REG_FRONT_DEPTH     = cfg_idx_t'(5);
	localparam cfg_idx_t REG_SIDE_RANGE      = cfg_idx_t'(6);

	// Reset values, ranges kept as squares
	localparam reg_t MIN_RANGE_RST       = reg_t'(0);
	localparam reg_t MAX_RANGE_RST       = reg_t'(100000);
	localparam reg_t REAR_HALF_WIDTH_RST = reg_t'(220);
	localparam reg_t REAR_LENGTH_RST     = reg_t'(800);
	localparam reg_t FRONT_DEPTH_RST     = reg_t'(50);
	localparam reg_t SIDE_RANGE_RST      = reg_t'(200);

	localparam reg_sq_t MIN_RANGE_SQ_RST =
		reg_sq_t'(MIN_RANGE_RST) * reg_sq_t'(MIN_RANGE_RST);
	localparam reg_sq_t MAX_RANGE_SQ_RST =
		reg_sq_t'(MAX_RANGE_RST) * reg_sq_t'(MAX_RANGE_RST);
	localparam reg_sq_t SIDE_RANGE_SQ_RST =
		reg_sq_t'(SIDE_RANGE_RST) * reg_sq_t'(SIDE_RANGE_RST);

endpackage

`default_nettype wire

[design/lprf_point_if.sv]
// ----------------------------------------------------------------------------
// lprf_point_if
// Valid/ready channel carrying one lidar point request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprf_point_if #(
	parameter int COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_mm;
	logic signed [COORD_WIDTH-1:0] y_mm;
	logic signed [COORD_WIDTH-1:0] z_mm;
	logic                          coord_invalid;
	logic                          frame_end;

	modport source (
		output valid, x_mm, y_mm, z_mm, coord_invalid, frame_end,
		input  ready
	);

	modport sink (
		input  valid, x_mm, y_mm, z_mm, coord_invalid, frame_end,
		output ready
	);
endinterface

`default_nettype wire

[design/lprf_result_if.sv]
// ----------------------------------------------------------------------------
// lprf_result_if
// Valid/ready channel carrying one filtered point result request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprf_result_if #(
	parameter int COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = lprf_pkg::COUNT_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          keep;
	logic signed [COORD_WIDTH-1:0] x_out_mm;
	logic signed [COORD_WIDTH-1:0] y_out_mm;
	logic signed [COORD_WIDTH-1:0] z_out_mm;
	logic [COUNT_WIDTH-1:0]        kept_so_far;
	logic                          frame_last;

	modport source (
		output valid, keep, x_out_mm, y_out_mm, z_out_mm, kept_so_far, frame_last,
		input  ready
	);

	modport sink (
		input  valid, keep, x_out_mm, y_out_mm, z_out_mm, kept_so_far, frame_last,
		output ready
	);
endinterface

`default_nettype wire

[design/lidar_point_region_filter.sv]
// ----------------------------------------------------------------------------
// lidar_point_region_filter: range and crop-box filter for a lidar point stream
// Each accepted point passes the input register, then the result register, before result valid.
// Throughput: one point per cycle; the input stalls only while a result waits on ready.
// Reset clears all stage valids and the kept counter, and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_point_region_filter_macros.svh"

module lidar_point_region_filter #(
	parameter int COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = lprf_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lprf_point_if.sink             point,
	lprf_result_if.source          result,
	input  wire logic              cfg_we,
	input  wire lprf_pkg::cfg_idx_t cfg_idx,
	input  wire lprf_pkg::reg_t    cfg_wdata
);
	import lprf_pkg::*;

	localparam int R2W = 2 * COORD_WIDTH;
	localparam int MW  = (COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;
	localparam int CW  = (R2W > SQ_WIDTH) ? R2W : SQ_WIDTH;

	// Configuration registers
	logic    filter_enable_q;
	reg_sq_t min_sq_q;
	reg_sq_t max_sq_q;
	reg_t    rear_half_q;
	reg_t    rear_length_q;
	reg_t    front_depth_q;
	reg_sq_t side_sq_q;
	reg_sq_t wdata_sq;

	assign wdata_sq = reg_sq_t'(cfg_wdata) * reg_sq_t'(cfg_wdata);

	// Decode register writes, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b1;
			min_sq_q        <= MIN_RANGE_SQ_RST;
			max_sq_q        <= MAX_RANGE_SQ_RST;
			rear_half_q     <= REAR_HALF_WIDTH_RST;
			rear_length_q   <= REAR_LENGTH_RST;
			front_depth_q   <= FRONT_DEPTH_RST;
			side_sq_q       <= SIDE_RANGE_SQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FILTER_ENABLE:   filter_enable_q <= cfg_wdata[0];
				REG_MIN_RANGE:       min_sq_q        <= wdata_sq;
				REG_MAX_RANGE:       max_sq_q        <= wdata_sq;
				REG_REAR_HALF_WIDTH: rear_half_q     <= cfg_wdata;
				REG_REAR_LENGTH:     rear_length_q   <= cfg_wdata;
				REG_FRONT_DEPTH:     front_depth_q   <= cfg_wdata;
				REG_SIDE_RANGE:      side_sq_q       <= wdata_sq;
				default: ;
			endcase
		end
	end

	// Stage handshake: each stage takes new data when empty or when it drains
	logic valid_s1, valid_s2;
	logic ready_s1, ready_s2;

	assign ready_s2    = !valid_s2 || result.ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign point.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= point.valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: input register
	logic [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic                   invalid_s1, last_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && point.valid) begin
			x_s1       <= point.x_mm;
			y_s1       <= point.y_mm;
			z_s1       <= point.z_mm;
			invalid_s1 <= point.coord_invalid;
			last_s1    <= point.frame_end;
		end
	end

	// Magnitudes, squares and the box tests
	logic [COORD_WIDTH-1:0] ax, ay, az;
	logic [R2W-1:0]         sqx, sqy, sqz;
	logic                   x_neg;
	logic                   zero_pt, rear_hit, front_hit, side_geo;

	assign x_neg = x_s1[COORD_WIDTH-1];
	assign ax    = x_neg ? (~x_s1 + 1'b1) : x_s1;
	assign ay    = y_s1[COORD_WIDTH-1] ? (~y_s1 + 1'b1) : y_s1;
	assign az    = z_s1[COORD_WIDTH-1] ? (~z_s1 + 1'b1) : z_s1;
	assign sqx   = R2W'(ax) * R2W'(ax);
	assign sqy   = R2W'(ay) * R2W'(ay);
	assign sqz   = R2W'(az) * R2W'(az);

	assign zero_pt   = (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
	assign rear_hit  = x_neg && (MW'(ax) <= MW'(rear_length_q))
		&& (MW'(ay) < MW'(rear_half_q));
	assign front_hit = !x_neg && (x_s1 != '0) && (MW'(ax) <= MW'(front_depth_q));
	assign side_geo  = (ay != '0) && !x_neg && (ay >= ax);

	// Range tests on the squared distance, then the keep decision
	logic [CW-1:0]          r2;
	logic                   early_rej, range_bad, side_bad, keep_pt;
	logic [COUNT_WIDTH-1:0] count_q, count_inc;

	assign r2        = CW'(sqx) + CW'(sqy) + CW'(sqz);
	assign early_rej = invalid_s1 || zero_pt || rear_hit || front_hit;
	assign range_bad = (r2 < CW'(min_sq_q)) || (r2 > CW'(max_sq_q));
	assign side_bad  = side_geo && (r2 < CW'(side_sq_q));
	assign keep_pt   = !filter_enable_q || !(early_rej || range_bad || side_bad);
	assign count_inc = (keep_pt && (count_q != '1)) ? (count_q + 1'b1) : count_q;

	// Kept counter: saturate, clear after the frame's last point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ready_s2 && valid_s1) begin
			count_q <= last_s1 ? '0 : count_inc;
		end
	end

	// Stage 2: result register
	logic [COORD_WIDTH-1:0] x_s2, y_s2, z_s2;
	logic [COUNT_WIDTH-1:0] kept_s2;
	logic                   keep_s2, last_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			kept_s2 <= count_inc;
			keep_s2 <= keep_pt;
			last_s2 <= last_s1;
		end
	end

	assign result.valid       = valid_s2;
	assign result.keep        = keep_s2;
	assign result.x_out_mm    = x_s2;
	assign result.y_out_mm    = y_s2;
	assign result.z_out_mm    = z_s2;
	assign result.kept_so_far = kept_s2;
	assign result.frame_last  = last_s2;

	// Checks
	`LPRF_ASSERT_NEXT(a_clear_after_last, ready_s2 && valid_s1 && last_s1, count_q == '0, "kept counter not cleared after frame end")
	`LPRF_ASSERT_SAME(a_kept_nonzero, valid_s2 && keep_s2, kept_s2 != '0, "kept point reported with zero count")
	`LPRF_ASSERT_NEXT(a_count_monotonic, ready_s2 && valid_s1 && !last_s1, count_q >= $past(count_q), "kept counter decreased within a frame")

endmodule

`default_nettype wire

[sim/tb_lidar_point_region_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_point_region_filter
// Streams lidar points through the region filter and checks every result
// against a cycle-free model of the keep decision and the per-frame counter.
// A directed table covers the reset settings, the boundaries of each reject
// region and the filter bypass. Random phases then sweep register settings
// with random idling on both channels in most phases, plus one long output stall.
// ----------------------------------------------------------------------------

module tb_lidar_point_region_filter;
	import lprf_pkg::*;

	localparam int COORD_WIDTH  = COORD_WIDTH_DEF;
	localparam int COUNT_WIDTH  = COUNT_WIDTH_DEF;
	localparam int PIPE_LATENCY = 2;
	localparam int PHASES       = 8;
	localparam int PHASE_POINTS = 157;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_LIMIT = 20000;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DIR_ROWS     = 25;

	// Index past the register list; writes to it must be dropped
	localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(NUM_REGS);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COUNT_WIDTH-1:0]        count_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   invalid;
		logic   fend;
	} point_t;

	typedef struct packed {
		logic   keep;
		coord_t x;
		coord_t y;
		coord_t z;
		count_t kept;
		logic   last;
	} filt_result_t;

	typedef struct packed {
		logic   filter_on;
		point_t pt;
		logic   typed;
		logic   keep;
		count_t kept;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	reg_t cfg_wdata;

	lprf_point_if #(.COORD_WIDTH(COORD_WIDTH)) point_ch ();
	lprf_result_if #(.COORD_WIDTH(COORD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) result_ch ();

	lidar_point_region_filter #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Register shadow and kept counter of the model
	logic cfg_enable;
	reg_t cfg_min;
	reg_t cfg_max;
	reg_t cfg_rear_hw;
	reg_t cfg_rear_len;
	reg_t cfg_front;
	reg_t cfg_side;
	count_t frame_kept;

	filt_result_t pending_filtered [$];
	filt_result_t oldest_filtered;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int errors = 0;
	int unsigned cycle_count = 0;
	logic stall_sink;
	event hold_kick;
	dir_row_t point_table [DIR_ROWS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Keep decision and running count for one point; advances the counter
	function automatic filt_result_t filter_point(point_t pt);
		longint x, y, z, ax, ay, az, r2;
		longint mn, mx, sr, rl, rw, fd;
		logic pass;
		filt_result_t r;
		x = longint'($signed(pt.x));
		y = longint'($signed(pt.y));
		z = longint'($signed(pt.z));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		r2 = ax * ax + ay * ay + az * az;
		mn = longint'(cfg_min);
		mx = longint'(cfg_max);
		sr = longint'(cfg_side);
		rl = longint'(cfg_rear_len);
		rw = longint'(cfg_rear_hw);
		fd = longint'(cfg_front);
		pass = 1'b1;
		if (pt.invalid)
			pass = 1'b0;
		else if (x == 0 && y == 0 && z == 0)
			pass = 1'b0;
		else if (r2 < mn * mn || r2 > mx * mx)
			pass = 1'b0;
		else if (x < 0 && x >= -rl && ay < rw)
			pass = 1'b0;
		else if (x > 0 && x <= fd)
			pass = 1'b0;
		else if (ay > 0 && x >= 0 && ay >= x && r2 < sr * sr)
			pass = 1'b0;
		if (!cfg_enable)
			pass = 1'b1;
		if (pass && frame_kept != '1)
			frame_kept = frame_kept + count_t'(1);
		r.keep = pass;
		r.x    = pt.x;
		r.y    = pt.y;
		r.z    = pt.z;
		r.kept = frame_kept;
		r.last = pt.fend;
		// Clear the count once the frame closes
		if (pt.fend)
			frame_kept = '0;
		return r;
	endfunction

	function automatic dir_row_t make_row(bit on, int x, int y, int z, bit inv, bit fend,
			bit typed, bit keep, int kept);
		dir_row_t row;
		row.filter_on  = on;
		row.pt.x       = coord_t'(x);
		row.pt.y       = coord_t'(y);
		row.pt.z       = coord_t'(z);
		row.pt.invalid = inv;
		row.pt.fend    = fend;
		row.typed      = typed;
		row.keep       = keep;
		row.kept       = count_t'(kept);
		return row;
	endfunction

	function automatic int spread(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic int nudge();
		return int'($urandom_range(0, 4)) - 2;
	endfunction

	function automatic int pick_sign();
		return ($urandom_range(0, 1) == 1) ? 1 : -1;
	endfunction

	function automatic int pick_scale();
		case ($urandom_range(0, 3))
			0: return 300;
			1: return 3000;
			2: return 30000;
			default: return 131071;
		endcase
	endfunction

	// Some points near the edges of the current regions, the rest noise at random scales
	function automatic point_t random_point();
		point_t p;
		int t;
		int s;
		p.z = '0;
		case ($urandom_range(0, 9))
			0: begin
				p.x = coord_t'($urandom);
				p.y = coord_t'($urandom);
				p.z = coord_t'($urandom);
			end
			1: begin
				p.x = coord_t'(int'(cfg_front) + nudge());
				p.y = coord_t'(spread(60));
			end
			2: begin
				p.x = coord_t'(-int'(cfg_rear_len) + nudge());
				p.y = coord_t'(pick_sign() * (int'(cfg_rear_hw) + nudge()));
				p.z = coord_t'(spread(100));
			end
			3: begin
				t = int'($urandom_range(0, cfg_side));
				p.x = coord_t'(t);
				p.y = coord_t'(pick_sign() * (t + nudge()));
			end
			4: begin
				t = ($urandom_range(0, 1) == 1) ? int'(cfg_max) : int'(cfg_min);
				p.x = coord_t'(pick_sign() * (t + nudge()));
				p.y = coord_t'(spread(1));
			end
			default: begin
				s = pick_scale();
				p.x = ($urandom_range(0, 5) == 0) ? coord_t'(0) : coord_t'(spread(s));
				p.y = ($urandom_range(0, 5) == 0) ? coord_t'(0) : coord_t'(spread(s));
				p.z = ($urandom_range(0, 5) == 0) ? coord_t'(0) : coord_t'(spread(s));
			end
		endcase
		p.invalid = ($urandom_range(0, 19) == 0);
		p.fend    = ($urandom_range(0, 24) == 0);
		return p;
	endfunction

	// Offer one point, hold it until taken, then queue its expected result
	task automatic send_point(point_t pt, logic use_typed, filt_result_t typed);
		filt_result_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			point_ch.valid <= 1'b0;
			@(negedge clk);
		end
		point_ch.valid         <= 1'b1;
		point_ch.x_mm          <= pt.x;
		point_ch.y_mm          <= pt.y;
		point_ch.z_mm          <= pt.z;
		point_ch.coord_invalid <= pt.invalid;
		point_ch.frame_end     <= pt.fend;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
		r = filter_point(pt);
		pending_filtered.push_back(use_typed ? typed : r);
		@(negedge clk);
	endtask

	// Register write; caller lowers the enable after the last one
	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= reg_t'(val);
		@(negedge clk);
		case (idx)
			REG_FILTER_ENABLE:   cfg_enable   = val[0];
			REG_MIN_RANGE:       cfg_min      = reg_t'(val);
			REG_MAX_RANGE:       cfg_max      = reg_t'(val);
			REG_REAR_HALF_WIDTH: cfg_rear_hw  = reg_t'(val);
			REG_REAR_LENGTH:     cfg_rear_len = reg_t'(val);
			REG_FRONT_DEPTH:     cfg_front    = reg_t'(val);
			REG_SIDE_RANGE:      cfg_side     = reg_t'(val);
			default: ;
		endcase
	endtask

	task automatic write_regions(int unsigned mn, int unsigned mx, int unsigned rw,
			int unsigned rl, int unsigned fd, int unsigned sr);
		write_reg(REG_MIN_RANGE, mn);
		write_reg(REG_MAX_RANGE, mx);
		write_reg(REG_REAR_HALF_WIDTH, rw);
		write_reg(REG_REAR_LENGTH, rl);
		write_reg(REG_FRONT_DEPTH, fd);
		write_reg(REG_SIDE_RANGE, sr);
	endtask

	// Drop valid and wait for the pipe to empty
	task automatic settle();
		int waited;
		waited = 0;
		point_ch.valid <= 1'b0;
		while (pending_filtered.size() != 0 && waited < SETTLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// Output side: random backpressure, forced low during a long hold
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= !stall_sink && ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Long output hold, counted here so the sender keeps offering meanwhile
	initial begin
		stall_sink = 1'b0;
		forever begin
			@(hold_kick);
			@(negedge clk);
			stall_sink <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			stall_sink <= 1'b0;
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_filtered.size() == 0) begin
				report_mismatch("result with none pending", 1, 0);
			end else begin
				oldest_filtered = pending_filtered.pop_front();
				if (result_ch.keep !== oldest_filtered.keep)
					report_mismatch("keep", longint'(result_ch.keep),
						longint'(oldest_filtered.keep));
				if (result_ch.x_out_mm !== oldest_filtered.x)
					report_mismatch("x_out_mm", longint'(result_ch.x_out_mm),
						longint'($signed(oldest_filtered.x)));
				if (result_ch.y_out_mm !== oldest_filtered.y)
					report_mismatch("y_out_mm", longint'(result_ch.y_out_mm),
						longint'($signed(oldest_filtered.y)));
				if (result_ch.z_out_mm !== oldest_filtered.z)
					report_mismatch("z_out_mm", longint'(result_ch.z_out_mm),
						longint'($signed(oldest_filtered.z)));
				if (result_ch.kept_so_far !== oldest_filtered.kept)
					report_mismatch("kept_so_far", longint'(result_ch.kept_so_far),
						longint'(oldest_filtered.kept));
				if (result_ch.frame_last !== oldest_filtered.last)
					report_mismatch("frame_last", longint'(result_ch.frame_last),
						longint'(oldest_filtered.last));
			end
		end
	end

	initial begin : stimulus
		int p;
		int n;
		int unsigned mn;
		point_t pt;
		filt_result_t typed;
		dir_row_t row;

		arst_n                 = 1'b0;
		point_ch.valid         = 1'b0;
		point_ch.x_mm          = '0;
		point_ch.y_mm          = '0;
		point_ch.z_mm          = '0;
		point_ch.coord_invalid = 1'b0;
		point_ch.frame_end     = 1'b0;
		cfg_we                 = 1'b0;
		cfg_idx                = REG_FILTER_ENABLE;
		cfg_wdata              = '0;
		cfg_enable             = 1'b1;
		cfg_min                = MIN_RANGE_RST;
		cfg_max                = MAX_RANGE_RST;
		cfg_rear_hw            = REAR_HALF_WIDTH_RST;
		cfg_rear_len           = REAR_LENGTH_RST;
		cfg_front              = FRONT_DEPTH_RST;
		cfg_side               = SIDE_RANGE_RST;
		frame_kept             = '0;

		// Reset settings, then the bypass, then filtering again
		point_table = '{
			make_row(1, 1000, 0, 0, 0, 0, 1, 1, 1),
			make_row(1, 0, 0, 0, 0, 0, 1, 0, 1),             // all zero
			make_row(1, 1000, 0, 0, 1, 0, 1, 0, 1),          // invalid
			make_row(1, 131071, 131071, 131071, 0, 0, 1, 0, 1),
			make_row(1, -131072, -131072, -131072, 0, 0, 1, 0, 1),
			make_row(1, -400, 100, 0, 0, 0, 1, 0, 1),        // rear box
			make_row(1, -400, 300, 0, 0, 0, 1, 1, 2),
			make_row(1, 30, 0, 0, 0, 0, 1, 0, 2),            // front slab
			make_row(1, 100, 150, 0, 0, 0, 1, 0, 2),         // side sector
			make_row(1, 0, 100, 0, 0, 0, 1, 0, 2),
			make_row(1, 0, 0, 100, 0, 0, 1, 1, 3),
			make_row(1, 0, 0, -131072, 0, 1, 1, 0, 3),       // frame end
			make_row(1, 60, 0, 0, 0, 1, 1, 1, 1),
			make_row(1, -801, 0, 0, 0, 0, 1, 1, 1),
			make_row(1, -800, 219, 0, 0, 0, 1, 0, 1),
			make_row(1, 51, 0, 0, 0, 0, 1, 1, 2),
			make_row(1, 50, 0, 0, 0, 0, 1, 0, 2),
			make_row(1, 200, 200, 0, 0, 0, 1, 1, 3),
			make_row(1, 100000, 0, 0, 0, 0, 1, 1, 4),        // at max range
			make_row(1, 100001, 0, 0, 0, 1, 1, 0, 4),
			make_row(0, 0, 0, 0, 1, 0, 1, 1, 1),             // bypass keeps all
			make_row(0, 0, 0, 0, 0, 0, 1, 1, 2),
			make_row(0, 131071, -131072, 0, 1, 1, 1, 1, 3),
			make_row(1, -5, -3, 7, 0, 0, 0, 0, 0),
			make_row(1, -131072, 5, 131071, 0, 0, 0, 0, 0)
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		for (n = 0; n < DIR_ROWS; n++) begin
			row = point_table[n];
			if (row.filter_on != cfg_enable) begin
				settle();
				write_reg(REG_FILTER_ENABLE, {31'd0, row.filter_on});
				cfg_we <= 1'b0;
			end
			typed.keep = row.keep;
			typed.x    = row.pt.x;
			typed.y    = row.pt.y;
			typed.z    = row.pt.z;
			typed.kept = row.kept;
			typed.last = row.pt.fend;
			send_point(row.pt, row.typed, typed);
		end

		// Random phases over a sweep of register settings
		for (p = 0; p < PHASES; p++) begin
			settle();
			if (p < 3) begin
				src_idle_pct = 38;
				snk_idle_pct = 45;
			end else if (p < 6) begin
				src_idle_pct = 45;
				snk_idle_pct = 38;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			case (p)
				0: write_reg(REG_FILTER_ENABLE, 1);
				1: begin
					write_reg(REG_FILTER_ENABLE, 0);
					write_reg(REG_UNUSED, 'h1FFFF);
				end
				2: begin
					// Minimum above maximum rejects every valid point
					write_reg(REG_FILTER_ENABLE, 1);
					write_regions(131071, 0, 220, 800, 50, 200);
				end
				3: write_regions(0, 131071, 131071, 131071, 131071, 131071);
				4: write_regions(0, 131071, 0, 0, 0, 0);
				default: begin
					mn = $urandom_range(0, 3000);
					write_regions(mn, $urandom_range(2000, 131071), $urandom_range(0, 4000),
						$urandom_range(0, 6000), $urandom_range(0, 3000),
						$urandom_range(0, 5000));
				end
			endcase
			cfg_we <= 1'b0;
			if (p == 6)
				-> hold_kick;
			for (n = 0; n < PHASE_POINTS; n++) begin
				pt = random_point();
				send_point(pt, 1'b0, typed);
			end
		end

		settle();
		if (pending_filtered.size() != 0)
			report_mismatch("results never delivered", 0, pending_filtered.size());
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[lidar_point_region_filter.f]
+incdir+design
design/lprf_pkg.sv
design/lprf_point_if.sv
design/lprf_result_if.sv
design/lidar_point_region_filter.sv
sim/tb_lidar_point_region_filter.sv
